// File: rtl/core/pdds_pkg.sv
// ----------------------------------------------------------------------------
// PD differential drive steering package
// Shared widths, register indexes, divider constants and the cosine table.
// ----------------------------------------------------------------------------
package pdds_pkg;

    localparam int COS_TABLE_DEPTH = 360;
    localparam int DEG_TURN        = 360;
    localparam int PIPE_DEPTH      = 24;
    localparam int SQRT_STAGES     = 6;
    localparam int CFG_IDX_W       = 8;

    localparam logic [63:0] PIHALF_Q30 = 64'd1686629713;

    localparam logic [CFG_IDX_W-1:0] CFG_KP_ANGLE     = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KD_ANGLE     = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KP_DIST      = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KD_DIST      = 8'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_GAIN    = 8'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FORWARD_GAIN = 8'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_MAX     = 8'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_DUTY    = 8'd7;

    localparam logic [31:0] RECIP_5    = 32'((64'd1 << 32) / 64'd5);
    localparam logic [31:0] RECIP_10   = 32'((64'd1 << 32) / 64'd10);
    localparam logic [31:0] RECIP_18   = 32'((64'd1 << 32) / 64'd18);
    localparam logic [31:0] RECIP_50   = 32'((64'd1 << 32) / 64'd50);
    localparam logic [31:0] RECIP_360  = 32'((64'd1 << 32) / 64'd360);
    localparam logic [31:0] RECIP_1000 = 32'((64'd1 << 32) / 64'd1000);

    typedef logic signed [15:0] t_cos_lut [DEG_TURN];

    typedef struct packed {
        logic [23:0] rem;
        logic [11:0] root;
    } t_sqrt;

    // Quotient estimate that is exact or one too small.
    function automatic logic [23:0] div_est(input logic [23:0] x, input logic [31:0] m);
        logic [55:0] p;
        p = {32'd0, x} * {24'd0, m};
        return p[55:32];
    endfunction

    function automatic logic [23:0] div_fix(input logic [23:0] x, input logic [23:0] q,
                                            input logic [23:0] d);
        logic [47:0] prod;
        logic [23:0] r;
        prod = {24'd0, q} * {24'd0, d};
        r    = x - prod[23:0];
        return (r >= d) ? q + 24'd1 : q;
    endfunction

    // One bit of a restoring square root.
    function automatic t_sqrt sqrt_bit(input t_sqrt s, input int b);
        t_sqrt       res;
        logic [25:0] t;
        res = s;
        t   = ({14'd0, s.root} << (b + 1)) + (26'd1 << (2 * b));
        if ({2'b00, s.rem} >= t) begin
            res.rem  = s.rem - t[23:0];
            res.root = s.root | (12'd1 << b);
        end
        return res;
    endfunction

    function automatic logic [15:0] quarter_cos(input logic [31:0] r);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        q;
        x    = (PIHALF_Q30 * {32'd0, r}) / 64'(COS_TABLE_DEPTH);
        x2   = (x * x) >> 30;
        term = 64'd1 << 30;
        sum  = signed'(term);
        for (int k = 1; k <= 7; k++) begin
            term = (term * x2) >> 30;
            term = term / 64'((2 * k - 1) * (2 * k));
            if (k[0]) begin
                sum = sum - signed'(term);
            end else begin
                sum = sum + signed'(term);
            end
        end
        if (sum <= 0) begin
            return 16'd0;
        end
        q = (unsigned'(sum) + (64'd1 << 15)) >> 16;
        if (q > 64'd16384) begin
            q = 64'd16384;
        end
        return q[15:0];
    endfunction

    function automatic logic signed [15:0] cos_entry(input logic [31:0] idx);
        logic [31:0]        n;
        logic [31:0]        q;
        logic [31:0]        r;
        logic signed [15:0] v;
        n = idx * 32'd4;
        q = n / 32'(COS_TABLE_DEPTH);
        r = n % 32'(COS_TABLE_DEPTH);
        case (q[1:0])
            2'd0:    v = signed'(quarter_cos(r));
            2'd1:    v = -signed'(quarter_cos(32'(COS_TABLE_DEPTH) - r));
            2'd2:    v = -signed'(quarter_cos(r));
            default: v = signed'(quarter_cos(32'(COS_TABLE_DEPTH) - r));
        endcase
        return v;
    endfunction

    function automatic t_cos_lut build_cos_lut();
        t_cos_lut lut;
        for (int d = 0; d < DEG_TURN; d++) begin
            lut[d] = cos_entry(32'(d * COS_TABLE_DEPTH / DEG_TURN));
        end
        return lut;
    endfunction

    localparam t_cos_lut COS_LUT = build_cos_lut();

endpackage

// File: rtl/core/pdds_if.sv
// ----------------------------------------------------------------------------
// PD differential drive steering channels
// Pose request, duty result and register write channels.
// ----------------------------------------------------------------------------
interface pdds_in_if;
    logic               valid;
    logic               ready;
    logic signed [10:0] pos_x;
    logic signed [10:0] pos_y;
    logic signed [9:0]  heading;
    logic signed [10:0] target_x;
    logic signed [10:0] target_y;
    logic signed [9:0]  target_heading;
    logic signed [10:0] prev_x;
    logic signed [10:0] prev_y;
    logic signed [9:0]  prev_heading;

    modport source (output valid, pos_x, pos_y, heading, target_x, target_y,
                    target_heading, prev_x, prev_y, prev_heading, input ready);
    modport sink (input valid, pos_x, pos_y, heading, target_x, target_y,
                  target_heading, prev_x, prev_y, prev_heading, output ready);
endinterface

interface pdds_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] left_duty;
    logic [7:0] right_duty;
    logic [9:0] distance;

    modport source (output valid, left_duty, right_duty, distance, input ready);
    modport sink (input valid, left_duty, right_duty, distance, output ready);
endinterface

interface pdds_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] index;
    logic [7:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/core/pd_differential_drive_steering_top.sv
// Throughput: one request per cycle; the whole pipeline holds while the result waits.
// The two square roots take two bits per stage over six stages.
// Reset clears the pipeline valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
// PD differential drive steering top level
// Angle and distance PD terms turned into clamped left and right wheel duties.
// ----------------------------------------------------------------------------
module pd_differential_drive_steering_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pdds_in_if.sink   i_in,
    pdds_out_if.source o_out,
    pdds_cfg_if.sink  i_cfg
);
    import pdds_pkg::*;

    function automatic logic [21:0] sq12(input logic signed [11:0] v);
        logic signed [23:0] p;
        p = 24'(v) * 24'(v);
        return p[21:0];
    endfunction

    function automatic logic [7:0] clamp(input logic signed [19:0] v, input logic [7:0] dmax);
        if (v >= signed'({12'd0, dmax})) begin
            return dmax;
        end else if (v < 0) begin
            return 8'd0;
        end
        return v[7:0];
    endfunction

    logic [7:0] r_kp_angle, r_kd_angle, r_kp_dist, r_kd_dist;
    logic [3:0] r_turn_gain, r_forward_gain;
    logic [7:0] r_duty_max, r_base_duty;

    logic                  en;
    logic [PIPE_DEPTH-1:0] r_vld;

    logic signed [10:0] r1_at, r1_ac;
    logic signed [11:0] r1_dx, r1_dy, r1_ox, r1_oy;
    logic signed [19:0] r2_pa, r2_pd;
    logic [21:0]        r2_dx2, r2_dy2, r2_ox2, r2_oy2;
    logic [11:0]        r2_ca, r2_cq0;
    logic [19:0]        r3_anm;
    logic [22:0]        r3_sum;
    logic [8:0]         r3_deg;
    logic [19:0]        r4_anm, r4_aq0;
    logic [22:0]        r4_sum;
    logic [13:0]        r4_dq0;
    logic [15:0]        r5_apd1;
    logic [13:0]        r5_s;
    logic [18:0]        r6_n2, r7_n2;
    logic [19:0]        r6_n;
    logic [14:0]        r7_aq0;
    logic [13:0]        r8_apd2, r9_apd2;
    logic [11:0]        r9_aq0, r10_rs;
    logic signed [25:0] r13_p;
    logic signed [12:0] r13_dd;
    logic [9:0]         r14_dm;
    logic [17:0]        r15_kpd, r16_kpd;
    logic [14:0]        r16_q0, r17_d1;
    logic [20:0]        r18_nm, r19_nm;
    logic [16:0]        r19_q0, r20_d2, r21_d2;
    logic [10:0]        r21_q0;
    logic signed [11:0] r22_fwd;
    logic signed [16:0] r23_ff;
    logic [7:0]         r24_left, r24_right;

    logic               r_ans [3:10];
    logic signed [15:0] r_cos [4:12];
    logic [22:0]        r_osum [3:6];
    logic signed [20:0] r_kdd [14:17];
    logic               r_ds [14:17];
    logic               r_ns [18:21];
    logic [9:0]         r_mag [13:24];
    logic signed [16:0] r_ts [11:23];
    t_sqrt              r_sqm [SQRT_STAGES];
    t_sqrt              r_sqo [SQRT_STAGES];

    logic [11:0]        n_ca;
    logic signed [20:0] n_an;
    logic [23:0]        n_cq, n_deg;
    logic [16:0]        n_tsm;
    logic signed [25:0] n_pabs;
    logic signed [16:0] n_d1s;
    logic signed [21:0] n_num;
    logic [10:0]        n_fm;
    logic signed [19:0] n_left, n_right;

    assign en           = !r_vld[PIPE_DEPTH-1] || o_out.ready;
    assign i_in.ready   = en;
    assign i_cfg.ready  = 1'b1;
    assign o_out.valid  = r_vld[PIPE_DEPTH-1];
    assign o_out.left_duty  = r24_left;
    assign o_out.right_duty = r24_right;
    assign o_out.distance   = r_mag[24];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp_angle     <= 8'd20;
            r_kd_angle     <= 8'd2;
            r_kp_dist      <= 8'd20;
            r_kd_dist      <= 8'd2;
            r_turn_gain    <= 4'd4;
            r_forward_gain <= 4'd1;
            r_duty_max     <= 8'd190;
            r_base_duty    <= 8'd180;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_KP_ANGLE:     r_kp_angle     <= i_cfg.data;
                CFG_KD_ANGLE:     r_kd_angle     <= i_cfg.data;
                CFG_KP_DIST:      r_kp_dist      <= i_cfg.data;
                CFG_KD_DIST:      r_kd_dist      <= i_cfg.data;
                CFG_TURN_GAIN:    r_turn_gain    <= i_cfg.data[3:0];
                CFG_FORWARD_GAIN: r_forward_gain <= i_cfg.data[3:0];
                CFG_DUTY_MAX:     r_duty_max     <= i_cfg.data;
                CFG_BASE_DUTY:    r_base_duty    <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], i_in.valid};
        end
    end

    always_comb begin
        n_ca   = 12'(13'(r1_at) + 13'sd1080);
        n_an   = 21'(r2_pa) - 21'(r2_pd);
        n_cq   = div_fix({12'd0, r2_ca}, {12'd0, r2_cq0}, 24'd360);
        n_deg  = {12'd0, r2_ca} - 24'(n_cq * 24'd360);
        n_tsm  = 17'(r10_rs) * 17'(r_turn_gain);
        n_pabs = r13_p[25] ? -r13_p : r13_p;
        n_d1s  = r_ds[17] ? -signed'({2'b00, r17_d1}) : signed'({2'b00, r17_d1});
        n_num  = 22'(n_d1s) * 22'sd10 - 22'(r_kdd[17]);
        n_fm   = 11'(div_fix({7'd0, r21_d2}, {13'd0, r21_q0}, 24'd50));
        n_left  = 20'(signed'({1'b0, r_base_duty})) - 20'(r_ts[23]) + 20'(r23_ff);
        n_right = 20'(signed'({1'b0, r_base_duty})) + 20'(r_ts[23]) + 20'(r23_ff);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_at <= 11'(i_in.target_heading) - 11'(i_in.heading);
            r1_ac <= 11'(i_in.heading) - 11'(i_in.prev_heading);
            r1_dx <= 12'(i_in.pos_x) - 12'(i_in.target_x);
            r1_dy <= 12'(i_in.pos_y) - 12'(i_in.target_y);
            r1_ox <= 12'(i_in.pos_x) - 12'(i_in.prev_x);
            r1_oy <= 12'(i_in.pos_y) - 12'(i_in.prev_y);

            r2_pa  <= 20'(signed'({1'b0, r_kp_angle})) * 20'(r1_at);
            r2_pd  <= 20'(signed'({1'b0, r_kd_angle})) * 20'(r1_ac);
            r2_dx2 <= sq12(r1_dx);
            r2_dy2 <= sq12(r1_dy);
            r2_ox2 <= sq12(r1_ox);
            r2_oy2 <= sq12(r1_oy);
            r2_ca  <= n_ca;
            r2_cq0 <= 12'(div_est({12'd0, n_ca}, RECIP_360));

            r_ans[3]  <= n_an[20];
            r3_anm    <= n_an[20] ? 20'(-n_an) : 20'(n_an);
            r3_sum    <= 23'(r2_dx2) + 23'(r2_dy2);
            r_osum[3] <= 23'(r2_ox2) + 23'(r2_oy2);
            r3_deg    <= 9'(n_deg);

            r4_anm   <= r3_anm;
            r4_aq0   <= 20'(div_est({4'd0, r3_anm}, RECIP_10));
            r4_sum   <= r3_sum;
            r4_dq0   <= 14'(div_est({1'b0, r3_sum}, RECIP_1000));
            r_cos[4] <= COS_LUT[r3_deg];

            r5_apd1 <= 16'(div_fix({4'd0, r4_anm}, {4'd0, r4_aq0}, 24'd10));
            r5_s    <= 14'(div_fix({1'b0, r4_sum}, {10'd0, r4_dq0}, 24'd1000));

            r6_n2 <= 19'(r5_apd1) * 19'd5;
            r6_n  <= 20'(r5_s) * 20'd100;

            r7_n2  <= r6_n2;
            r7_aq0 <= 15'(div_est({5'd0, r6_n2}, RECIP_18));
            r8_apd2 <= 14'(div_fix({5'd0, r7_n2}, {9'd0, r7_aq0}, 24'd18));
            r9_apd2 <= r8_apd2;
            r9_aq0  <= 12'(div_est({10'd0, r8_apd2}, RECIP_5));
            r10_rs  <= 12'(div_fix({10'd0, r9_apd2}, {12'd0, r9_aq0}, 24'd5));
            r_ts[11] <= r_ans[10] ? -signed'(n_tsm) : signed'(n_tsm);

            r_sqm[0] <= sqrt_bit(sqrt_bit(t_sqrt'({4'd0, r6_n, 12'd0}), 11), 10);
            r_sqo[0] <= sqrt_bit(sqrt_bit(t_sqrt'({1'b0, r_osum[6], 12'd0}), 11), 10);
            for (int j = 1; j < SQRT_STAGES; j++) begin
                r_sqm[j] <= sqrt_bit(sqrt_bit(r_sqm[j-1], 11 - 2 * j), 10 - 2 * j);
                r_sqo[j] <= sqrt_bit(sqrt_bit(r_sqo[j-1], 11 - 2 * j), 10 - 2 * j);
            end

            r13_p     <= 26'(r_cos[12]) * 26'(signed'({1'b0, r_sqm[SQRT_STAGES-1].root[9:0]}));
            r13_dd    <= signed'({3'd0, r_sqm[SQRT_STAGES-1].root[9:0]})
                         - signed'({1'b0, r_sqo[SQRT_STAGES-1].root});
            r_mag[13] <= r_sqm[SQRT_STAGES-1].root[9:0];

            r14_dm    <= 10'(n_pabs >>> 14);
            r_ds[14]  <= r13_p[25];
            r_kdd[14] <= 21'(signed'({1'b0, r_kd_dist})) * 21'(r13_dd);

            r15_kpd <= 18'(r_kp_dist) * 18'(r14_dm);
            r16_kpd <= r15_kpd;
            r16_q0  <= 15'(div_est({6'd0, r15_kpd}, RECIP_10));
            r17_d1  <= 15'(div_fix({6'd0, r16_kpd}, {9'd0, r16_q0}, 24'd10));

            r_ns[18] <= n_num[21];
            r18_nm   <= n_num[21] ? 21'(-n_num) : 21'(n_num);
            r19_nm   <= r18_nm;
            r19_q0   <= 17'(div_est({3'd0, r18_nm}, RECIP_10));
            r20_d2   <= 17'(div_fix({3'd0, r19_nm}, {7'd0, r19_q0}, 24'd10));
            r21_d2   <= r20_d2;
            r21_q0   <= 11'(div_est({7'd0, r20_d2}, RECIP_50));
            r22_fwd  <= r_ns[21] ? -signed'({1'b0, n_fm}) : signed'({1'b0, n_fm});
            r23_ff   <= 17'(r22_fwd) * 17'(signed'({1'b0, r_forward_gain}));

            r24_left  <= clamp(n_left, r_duty_max);
            r24_right <= clamp(n_right, r_duty_max);

            for (int k = 4; k <= 10; k++) begin
                r_ans[k] <= r_ans[k-1];
            end
            for (int k = 5; k <= 12; k++) begin
                r_cos[k] <= r_cos[k-1];
            end
            for (int k = 4; k <= 6; k++) begin
                r_osum[k] <= r_osum[k-1];
            end
            for (int k = 15; k <= 17; k++) begin
                r_kdd[k] <= r_kdd[k-1];
                r_ds[k]  <= r_ds[k-1];
            end
            for (int k = 19; k <= 21; k++) begin
                r_ns[k] <= r_ns[k-1];
            end
            for (int k = 14; k <= 24; k++) begin
                r_mag[k] <= r_mag[k-1];
            end
            for (int k = 12; k <= 23; k++) begin
                r_ts[k] <= r_ts[k-1];
            end
        end
    end

`ifndef SYNTHESIS
    a_duty_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.left_duty <= r_duty_max) && (o_out.right_duty <= r_duty_max))
        else $error("wheel duty above the configured maximum");

    a_distance_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.distance <= 10'd915))
        else $error("distance beyond the largest reachable value");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_vld))
        else $error("pipeline occupancy changed during a stall");
`endif

endmodule

// File: bench/pdds_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// PD steering result checker
// Watches the pose, register and duty channels, computes the expected wheel
// duties and distance for every accepted request and compares them in order.
// ----------------------------------------------------------------------------
module pdds_checker (
    input  logic    i_clk,
    input  logic    i_rst_n,
    pdds_in_if      i_in,
    pdds_out_if     i_out,
    pdds_cfg_if     i_cfg,
    output int      o_fail_count,
    output int      o_pending
);
    import pdds_pkg::*;

    typedef struct packed {
        logic [7:0] left_duty;
        logic [7:0] right_duty;
        logic [9:0] distance;
    } t_duty_res;

    t_duty_res duty_queue[$];
    logic [7:0] kp_ang, kd_ang, kp_dst, kd_dst, max_duty, base;
    logic [3:0] turn_k, fwd_k;

    function automatic int unsigned int_sqrt(input int unsigned n);
        int unsigned root;
        int unsigned bitv;
        root = 0;
        bitv = 32'd1 << 30;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    function automatic int cos_q14(input int unsigned r_in, input bit neg_r);
        longint unsigned x, x2, term, q;
        longint          sum;
        int unsigned     r;
        r = neg_r ? COS_TABLE_DEPTH - r_in : r_in;
        x = 64'd1686629713 * r / COS_TABLE_DEPTH;
        x2 = (x * x) >> 30;
        term = 64'd1 << 30;
        sum = longint'(term);
        for (int k = 1; k <= 7; k++) begin
            term = (term * x2) >> 30;
            term = term / ((2 * k - 1) * (2 * k));
            if (k % 2) sum -= longint'(term);
            else sum += longint'(term);
        end
        if (sum <= 0) return 0;
        q = (longint'(sum) + (64'd1 << 15)) >> 16;
        if (q > 16384) q = 16384;
        return int'(q);
    endfunction

    function automatic int cos_of_index(input int unsigned idx);
        int unsigned n, q, r;
        n = idx * 4;
        q = n / COS_TABLE_DEPTH;
        r = n % COS_TABLE_DEPTH;
        case (q % 4)
            0: return cos_q14(r, 0);
            1: return -cos_q14(r, 1);
            2: return -cos_q14(r, 0);
            default: return cos_q14(r, 1);
        endcase
    endfunction

    function automatic logic [7:0] clamp_duty(input int v);
        if (v >= int'(max_duty)) return max_duty;
        if (v < 0) return 8'd0;
        return v[7:0];
    endfunction

    function automatic t_duty_res steer_predict();
        t_duty_res r;
        int at, ac, apd, rstep, dx, dy, ddx, ddy, mag, mold, deg, cq, derr, dpd, fwd;
        int unsigned s;
        at = int'(i_in.target_heading) - int'(i_in.heading);
        ac = int'(i_in.heading) - int'(i_in.prev_heading);
        apd = (int'(kp_ang) * at - int'(kd_ang) * ac) / 10;
        apd = apd * 100 / 360;
        rstep = apd * 2 / 10;
        dx = int'(i_in.pos_x) - int'(i_in.target_x);
        dy = int'(i_in.pos_y) - int'(i_in.target_y);
        s = unsigned'(dx * dx + dy * dy) / 1000;
        mag = int'(int_sqrt(s * 100));
        ddx = int'(i_in.pos_x) - int'(i_in.prev_x);
        ddy = int'(i_in.pos_y) - int'(i_in.prev_y);
        mold = int'(int_sqrt(unsigned'(ddx * ddx + ddy * ddy)));
        deg = ((at % 360) + 360) % 360;
        cq = cos_of_index(deg * COS_TABLE_DEPTH / 360);
        derr = cq * mag / 16384;
        dpd = int'(kp_dst) * derr / 10;
        dpd = (10 * dpd - int'(kd_dst) * (mag - mold)) / 10;
        fwd = dpd * 2 / 100;
        r.left_duty = clamp_duty(int'(base) - int'(turn_k) * rstep + int'(fwd_k) * fwd);
        r.right_duty = clamp_duty(int'(base) + int'(turn_k) * rstep + int'(fwd_k) * fwd);
        r.distance = mag[9:0];
        return r;
    endfunction

    assign o_pending = duty_queue.size();

    always @(posedge i_clk) begin
        t_duty_res want;
        if (!i_rst_n) begin
            kp_ang <= 8'd20; kd_ang <= 8'd2; kp_dst <= 8'd20; kd_dst <= 8'd2;
            turn_k <= 4'd4; fwd_k <= 4'd1; max_duty <= 8'd190; base <= 8'd180;
            o_fail_count <= 0;
            duty_queue.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    CFG_KP_ANGLE:     kp_ang <= i_cfg.data;
                    CFG_KD_ANGLE:     kd_ang <= i_cfg.data;
                    CFG_KP_DIST:      kp_dst <= i_cfg.data;
                    CFG_KD_DIST:      kd_dst <= i_cfg.data;
                    CFG_TURN_GAIN:    turn_k <= i_cfg.data[3:0];
                    CFG_FORWARD_GAIN: fwd_k <= i_cfg.data[3:0];
                    CFG_DUTY_MAX:     max_duty <= i_cfg.data;
                    CFG_BASE_DUTY:    base <= i_cfg.data;
                    default: ;
                endcase
            end
            if (i_in.valid && i_in.ready) duty_queue.push_back(steer_predict());
            if (i_out.valid && i_out.ready) begin
                if (duty_queue.size() == 0) begin
                    $display("%0t: unexpected result %0d %0d %0d", $time,
                             i_out.left_duty, i_out.right_duty, i_out.distance);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = duty_queue.pop_front();
                    if (want.left_duty !== i_out.left_duty ||
                        want.right_duty !== i_out.right_duty ||
                        want.distance !== i_out.distance) begin
                        $display("%0t: expected %0d %0d %0d, got %0d %0d %0d", $time,
                                 want.left_duty, want.right_duty, want.distance,
                                 i_out.left_duty, i_out.right_duty, i_out.distance);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

// File: bench/pd_differential_drive_steering_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// PD steering testbench
// Drives directed and random pose requests through several register settings
// with random stalls on both channels; the checker compares every result.
// ----------------------------------------------------------------------------
module pd_differential_drive_steering_top_tb;
    import pdds_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   fail_count;
    int   pending;
    int   cycle_count = 0;
    int   send_idle = 0;
    int   recv_idle = 0;

    pdds_in_if  in_ch();
    pdds_out_if out_ch();
    pdds_cfg_if cfg_ch();

    pd_differential_drive_steering_top u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch), .o_out(out_ch), .i_cfg(cfg_ch)
    );

    pdds_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch), .i_out(out_ch), .i_cfg(cfg_ch),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always #1 i_clk = ~i_clk;

    initial begin
        in_ch.valid = 0; in_ch.pos_x = 0; in_ch.pos_y = 0; in_ch.heading = 0;
        in_ch.target_x = 0; in_ch.target_y = 0; in_ch.target_heading = 0;
        in_ch.prev_x = 0; in_ch.prev_y = 0; in_ch.prev_heading = 0;
        out_ch.ready = 0;
        cfg_ch.valid = 0; cfg_ch.index = 0; cfg_ch.data = 0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle);
    end

    task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        cfg_ch.valid <= 1'b1;
        do @(posedge i_clk); while (!cfg_ch.ready);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        cfg_ch.valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH + 4) @(posedge i_clk);
    endtask

    task automatic send_pose(input logic [10:0] px, py, tx, ty, ox, oy,
                             input logic [9:0] hd, th, oh);
        cfg_ch.valid <= 1'b0;
        while ($urandom_range(99) < send_idle) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.pos_x <= px; in_ch.pos_y <= py; in_ch.heading <= hd;
        in_ch.target_x <= tx; in_ch.target_y <= ty; in_ch.target_heading <= th;
        in_ch.prev_x <= ox; in_ch.prev_y <= oy; in_ch.prev_heading <= oh;
        in_ch.valid <= 1'b1;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    function automatic logic [9:0] rand_angle();
        if ($urandom_range(9) == 0) return 10'($urandom);
        return 10'($signed($urandom_range(720)) - 360);
    endfunction

    task automatic send_random();
        logic [10:0] px, py;
        logic [9:0]  hd;
        px = 11'($urandom);
        py = 11'($urandom);
        hd = rand_angle();
        if ($urandom_range(3) == 0) begin
            send_pose(px, py, 11'($urandom), 11'($urandom), 11'($urandom), 11'($urandom),
                      hd, rand_angle(), rand_angle());
        end else begin
            send_pose(px, py, px + 11'($signed($urandom_range(400)) - 200),
                      py + 11'($signed($urandom_range(400)) - 200),
                      px + 11'($signed($urandom_range(20)) - 10),
                      py + 11'($signed($urandom_range(20)) - 10),
                      hd, hd + 10'($signed($urandom_range(360)) - 180),
                      hd + 10'($signed($urandom_range(20)) - 10));
        end
    endtask

    task automatic random_config();
        write_reg(CFG_KP_ANGLE, 8'($urandom));
        write_reg(CFG_KD_ANGLE, 8'($urandom));
        write_reg(CFG_KP_DIST, 8'($urandom));
        write_reg(CFG_KD_DIST, 8'($urandom));
        write_reg(CFG_TURN_GAIN, 8'($urandom));
        write_reg(CFG_FORWARD_GAIN, 8'($urandom));
        write_reg(CFG_DUTY_MAX, 8'($urandom));
        write_reg(CFG_BASE_DUTY, 8'($urandom));
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_idle = 7;
        recv_idle = 57;

        send_pose(0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_pose(11'h3FF, 11'h3FF, 11'h400, 11'h400, 11'h400, 11'h400, 360, -360, -360);
        send_pose(11'h400, 11'h400, 11'h3FF, 11'h3FF, 11'h3FF, 11'h3FF, -360, 360, 360);
        send_pose(100, 0, 0, 0, 90, 0, 0, 180, 0);
        send_pose(0, 0, 300, 400, 0, 0, 0, 90, 5);
        send_pose(0, 0, 300, 400, 10, 10, 359, -359, 0);
        send_pose(5, 5, 0, 0, 0, 0, 10'h1FF, 10'h200, 10'h3FF);
        send_pose(-500, 20, 500, -20, 0, 0, 10'h200, 10'h1FF, 10'h200);
        send_pose(31, 0, 0, 0, 31, 0, 270, -90, 270);
        drain();
        write_reg(CFG_DUTY_MAX, 0);
        write_reg(8'd200, 8'hFF);
        send_pose(0, 0, 300, 400, 0, 0, 0, 45, 0);
        send_pose(0, 0, 300, 400, 0, 0, 0, -45, 90);
        drain();
        write_reg(CFG_KP_ANGLE, 8'hFF); write_reg(CFG_KD_ANGLE, 8'hFF);
        write_reg(CFG_KP_DIST, 8'hFF);  write_reg(CFG_KD_DIST, 8'hFF);
        write_reg(CFG_TURN_GAIN, 8'hFF); write_reg(CFG_FORWARD_GAIN, 8'hFF);
        write_reg(CFG_DUTY_MAX, 8'hFF); write_reg(CFG_BASE_DUTY, 8'hFF);
        for (int i = 0; i < 12; i++) send_random();
        drain();

        for (int phase = 0; phase < 9; phase++) begin
            if (phase == 3) begin
                send_idle = 57; recv_idle = 7;
            end else if (phase == 6) begin
                send_idle = 0; recv_idle = 0;
            end
            if (phase == 4) begin
                write_reg(CFG_KP_ANGLE, 0); write_reg(CFG_KD_ANGLE, 0);
                write_reg(CFG_KP_DIST, 0);  write_reg(CFG_KD_DIST, 0);
                write_reg(CFG_TURN_GAIN, 0); write_reg(CFG_FORWARD_GAIN, 0);
                write_reg(CFG_BASE_DUTY, 0); write_reg(CFG_DUTY_MAX, 8'hFF);
            end else if (phase == 0) begin
                write_reg(CFG_KP_ANGLE, 20); write_reg(CFG_KD_ANGLE, 2);
                write_reg(CFG_KP_DIST, 20);  write_reg(CFG_KD_DIST, 2);
                write_reg(CFG_TURN_GAIN, 4); write_reg(CFG_FORWARD_GAIN, 1);
                write_reg(CFG_DUTY_MAX, 190); write_reg(CFG_BASE_DUTY, 180);
            end else begin
                random_config();
            end
            for (int i = 0; i < 100; i++) send_random();
            drain();
        end

        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
